>>> rtl/led_effect_sequencer_assert.svh
`ifndef LED_EFFECT_SEQUENCER_ASSERT_SVH
`define LED_EFFECT_SEQUENCER_ASSERT_SVH

// Check outside reset: the property is skipped while rst_n is low.
`define LES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also covers the reset cycles themselves.
`define LES_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/les_pkg.sv
package les_pkg;

  localparam int PERIOD_WIDTH = 24;
  localparam int PERIOD_RESET = 200000;

  localparam int OPCODE_W  = 4;
  localparam int ARG_W     = 8;
  localparam int LED_W     = 8;
  localparam int IDX_W     = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USED_W = LED_W + 2;

  localparam logic [OPCODE_W-1:0] OP_TICK    = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_ON      = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_OFF     = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_BAR     = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_MASK    = 4'd4;
  localparam logic [OPCODE_W-1:0] FX_SLIDE   = 4'd5;
  localparam logic [OPCODE_W-1:0] FX_BLINK   = 4'd6;
  localparam logic [OPCODE_W-1:0] FX_BISLIDE = 4'd7;
  localparam logic [OPCODE_W-1:0] FX_BIBLINK = 4'd8;
  localparam logic [OPCODE_W-1:0] FX_GROW    = 4'd9;
  localparam logic [OPCODE_W-1:0] FX_CENTER  = 4'd10;
  localparam logic [OPCODE_W-1:0] FX_SIDE    = 4'd11;
  localparam logic [OPCODE_W-1:0] FX_BISIDE  = 4'd12;
  localparam logic [OPCODE_W-1:0] FX_IDLE    = 4'd0;

  // Frame wait selectors
  localparam logic [1:0] WSEL_NONE = 2'd0;
  localparam logic [1:0] WSEL_8    = 2'd1;
  localparam logic [1:0] WSEL_2    = 2'd2;
  localparam logic [1:0] WSEL_9    = 2'd3;

  // Divide by nine as multiply by rounded-up reciprocal, exact below 2^PERIOD_WIDTH
  localparam int DIV9_SHIFT = PERIOD_WIDTH + 4;
  localparam logic [PERIOD_WIDTH:0] DIV9_MULT =
    (PERIOD_WIDTH+1)'(((64'd1 << DIV9_SHIFT) + 64'd8) / 64'd9);

  localparam logic [PERIOD_WIDTH-1:0] WAIT8_RESET = PERIOD_WIDTH'(PERIOD_RESET / 8);
  localparam logic [PERIOD_WIDTH-1:0] WAIT2_RESET = PERIOD_WIDTH'(PERIOD_RESET / 2);
  localparam logic [PERIOD_WIDTH-1:0] WAIT9_RESET = PERIOD_WIDTH'(PERIOD_RESET / 9);

  typedef struct packed {
    logic [LED_W-1:0]        leds;
    logic [OPCODE_W-1:0]     eff;
    logic [ARG_W-1:0]        cyc;
    logic [IDX_W-1:0]        idx;
    logic [PERIOD_WIDTH-1:0] wcnt;
    logic                    tail;
  } seq_state_t;

  typedef struct packed {
    logic [LED_W-1:0] leds;
    logic [1:0]       wsel;
  } frame_res_t;

  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] w8;
    logic [PERIOD_WIDTH-1:0] w2;
    logic [PERIOD_WIDTH-1:0] w9;
  } waits_t;

  function automatic logic [IDX_W-1:0] frames_of(logic [OPCODE_W-1:0] eff);
    logic [IDX_W-1:0] n;
    case (eff)
      FX_SLIDE:   n = 5'd9;
      FX_BLINK:   n = 5'd2;
      FX_BISLIDE: n = 5'd16;
      FX_BIBLINK: n = 5'd2;
      FX_GROW:    n = 5'd9;
      FX_CENTER:  n = 5'd5;
      FX_SIDE:    n = 5'd5;
      FX_BISIDE:  n = 5'd8;
      default:    n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/led_effect_sequencer.sv
// LED effect sequencer. Takes one command word per cycle on in_* and returns one
// result word per command on out_*, through a registered output. Ticks advance a
// running effect; every other command is rejected while an effect runs. All work
// for a word is one pass of short logic from the state registers to the result
// register, so the block sustains one word per cycle; a two-entry output buffer
// keeps in_tready high while one result waits, and in_tready drops only when
// both entries are full or rst_n is low. The period fractions (/8, /2, /9) are
// computed and registered when period_ticks is written, so a write takes effect
// on the next cycle's command.
module led_effect_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [les_pkg::PERIOD_WIDTH-1:0] cfg_wdata,   // period_ticks
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [les_pkg::IN_DATA_W-1:0]    in_tdata,    // opcode[3:0], argument[11:4]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [les_pkg::OUT_DATA_W-1:0]   out_tdata    // led_pattern[7:0], busy_res[8],
                                                        // rejected[9]
);
  import les_pkg::*;

  waits_t     waits_r;
  seq_state_t st_r, st_nxt;
  logic       rej;
  logic [OPCODE_W-1:0] op;
  logic [ARG_W-1:0]    arg;
  logic [2*PERIOD_WIDTH:0]  div9_prod;
  logic [PERIOD_WIDTH-1:0]  q8, q2, q9;

  logic                  out_valid_r, skid_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, skid_data_r, rsp;
  logic                  in_acc, pop;

  // ---------------------------------------------------------------- helpers
  function automatic logic [LED_W-1:0] led_set(logic [LED_W-1:0] v, int pos);
    if (pos >= 0 && pos < LED_W) v[pos[2:0]] = 1'b1;
    return v;
  endfunction

  function automatic logic [LED_W-1:0] led_clr(logic [LED_W-1:0] v, int pos);
    if (pos >= 0 && pos < LED_W) v[pos[2:0]] = 1'b0;
    return v;
  endfunction

  function automatic logic [LED_W-1:0] pair_step(logic [LED_W-1:0] v, int h,
                                                 logic lit, logic dark);
    logic [LED_W-1:0] r;
    r = v;
    if (lit) begin
      r = led_set(r, h - 1);
      r = led_set(r, 8 - h);
    end
    if (dark) begin
      r = led_clr(r, h - 2);
      r = led_clr(r, 9 - h);
    end
    return r;
  endfunction

  function automatic frame_res_t frame_apply(logic [OPCODE_W-1:0] eff,
                                             logic [IDX_W-1:0] idx,
                                             logic [LED_W-1:0] v);
    frame_res_t r;
    int i;
    int h;
    i = int'(idx);
    r.leds = v;
    r.wsel = WSEL_8;
    case (eff)
      FX_SLIDE: begin
        h = i + 1;
        if (h <= 8) r.leds = led_set(r.leds, h - 1);
        if (h != 1) r.leds = led_clr(r.leds, h - 2);
      end
      FX_BLINK: begin
        r.leds = (i == 0) ? 8'hFF : 8'h00;
        r.wsel = WSEL_2;
      end
      FX_BISLIDE: begin
        if (i < 8) begin
          r.leds = led_set(r.leds, i);
          if (i != 0) r.leds = led_clr(r.leds, i - 1);
        end else begin
          h = 16 - i;
          r.leds = led_set(r.leds, h - 1);
          if (h != 8) r.leds = led_clr(r.leds, h);
        end
      end
      FX_BIBLINK: begin
        r.leds = (i == 0) ? 8'h55 : 8'hAA;
        r.wsel = WSEL_2;
      end
      FX_GROW: begin
        if (i < 8) r.leds = led_set(r.leds, i);
        else r.leds = '0;
        r.wsel = WSEL_9;
      end
      FX_CENTER: begin
        h = i + 1;
        r.leds = pair_step(r.leds, h, h <= 4, h != 1);
      end
      FX_SIDE: begin
        h = i + 5;
        r.leds = pair_step(r.leds, h, h <= 8, h != 5);
      end
      FX_BISIDE: begin
        if (i < 4) begin
          h = i + 5;
          r.leds = pair_step(r.leds, h, 1'b1, h != 5);
          r.wsel = (h != 8) ? WSEL_8 : WSEL_NONE;
        end else begin
          h = i - 3;
          r.leds = pair_step(r.leds, h, 1'b1, h != 1);
          r.wsel = (h != 4) ? WSEL_8 : WSEL_NONE;
        end
      end
      default: r.wsel = WSEL_8;
    endcase
    return r;
  endfunction

  function automatic seq_state_t finish(seq_state_t s);
    seq_state_t r;
    r = s;
    r.eff  = FX_IDLE;
    r.cyc  = '0;
    r.idx  = '0;
    r.wcnt = '0;
    r.tail = 1'b0;
    return r;
  endfunction

  function automatic seq_state_t enter_tail(seq_state_t s, waits_t w);
    seq_state_t r;
    r = s;
    case (s.eff)
      FX_BISLIDE: begin
        r.leds = led_clr(r.leds, 0);
        r = finish(r);
      end
      FX_BIBLINK: begin
        r.leds = '0;
        r = finish(r);
      end
      FX_BISIDE: begin
        r.tail = 1'b1;
        r.wcnt = w.w8;
      end
      default: r = finish(r);
    endcase
    return r;
  endfunction

  function automatic seq_state_t advance(seq_state_t s, waits_t w, output logic ok);
    seq_state_t r;
    logic [IDX_W:0] nidx;
    r = s;
    ok = 1'b1;
    nidx = {1'b0, s.idx} + 1'b1;
    if (nidx >= {1'b0, frames_of(s.eff)}) begin
      r.idx = '0;
      r.cyc = s.cyc - 1'b1;
      if (r.cyc == '0) begin
        r = enter_tail(r, w);
        ok = 1'b0;
      end
    end else begin
      r.idx = nidx[IDX_W-1:0];
    end
    return r;
  endfunction

  // A zero-wait frame is always followed by one that waits, so two passes suffice
  function automatic seq_state_t play(seq_state_t s, waits_t w);
    seq_state_t r;
    frame_res_t fr;
    logic done;
    logic ok;
    r = s;
    done = 1'b0;
    ok = 1'b1;
    for (int k = 0; k < 2; k++) begin
      if (!done) begin
        fr = frame_apply(r.eff, r.idx, r.leds);
        r.leds = fr.leds;
        case (fr.wsel)
          WSEL_8:  begin r.wcnt = w.w8; done = 1'b1; end
          WSEL_2:  begin r.wcnt = w.w2; done = 1'b1; end
          WSEL_9:  begin r.wcnt = w.w9; done = 1'b1; end
          default: begin
            r = advance(r, w, ok);
            if (!ok) done = 1'b1;
          end
        endcase
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- period fractions
  assign div9_prod = {{PERIOD_WIDTH{1'b0}}, DIV9_MULT} * {{(PERIOD_WIDTH+1){1'b0}}, cfg_wdata};
  assign q8 = cfg_wdata >> 3;
  assign q2 = cfg_wdata >> 1;
  assign q9 = div9_prod[DIV9_SHIFT +: PERIOD_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waits_r.w8 <= WAIT8_RESET;
      waits_r.w2 <= WAIT2_RESET;
      waits_r.w9 <= WAIT9_RESET;
    end else if (cfg_wen) begin
      waits_r.w8 <= (q8 == '0) ? PERIOD_WIDTH'(1) : q8;
      waits_r.w2 <= (q2 == '0) ? PERIOD_WIDTH'(1) : q2;
      waits_r.w9 <= (q9 == '0) ? PERIOD_WIDTH'(1) : q9;
    end
  end

  // ---------------------------------------------------------------- command step
  assign op  = in_tdata[OPCODE_W-1:0];
  assign arg = in_tdata[OPCODE_W +: ARG_W];

  always_comb begin
    logic ok;
    st_nxt = st_r;
    rej = 1'b0;
    ok = 1'b1;
    if (op == OP_TICK) begin
      if (st_r.eff != FX_IDLE) begin
        if (st_r.wcnt > PERIOD_WIDTH'(1)) begin
          st_nxt.wcnt = st_r.wcnt - 1'b1;
        end else begin
          st_nxt.wcnt = '0;
          if (st_r.tail) begin
            st_nxt.leds = '0;
            st_nxt = finish(st_nxt);
          end else begin
            st_nxt = advance(st_nxt, waits_r, ok);
            if (ok) st_nxt = play(st_nxt, waits_r);
          end
        end
      end
    end else if (st_r.eff != FX_IDLE || op > FX_BISIDE) begin
      rej = 1'b1;
    end else if (op == OP_ON || op == OP_OFF) begin
      if (arg > 8'd8) rej = 1'b1;
      else if (arg == '0) st_nxt.leds = (op == OP_ON) ? 8'hFF : 8'h00;
      else if (op == OP_ON) st_nxt.leds = led_set(st_r.leds, int'(arg) - 1);
      else st_nxt.leds = led_clr(st_r.leds, int'(arg) - 1);
    end else if (op == OP_BAR) begin
      if (arg == '0 || arg > 8'd8) rej = 1'b1;
      else st_nxt.leds = LED_W'((9'd1 << arg[3:0]) - 9'd1);
    end else if (op == OP_MASK) begin
      st_nxt.leds = arg;
    end else begin
      st_nxt.eff  = op;
      st_nxt.cyc  = arg;
      st_nxt.idx  = '0;
      st_nxt.tail = 1'b0;
      st_nxt.wcnt = '0;
      if (arg == '0) st_nxt = enter_tail(st_nxt, waits_r);
      else st_nxt = play(st_nxt, waits_r);
    end
  end

  assign rsp = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, rej, st_nxt.eff != FX_IDLE, st_nxt.leds};

  // ---------------------------------------------------------------- handshake
  assign in_tready = rst_n && !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        // drain the second entry once the first is taken
        if (pop) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_r && !pop) skid_valid_r <= 1'b1;
        else out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_data_r <= skid_data_r;
    end else if (in_acc) begin
      if (out_valid_r && !pop) skid_data_r <= rsp;
      else out_data_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/les_checker.sv
`include "led_effect_sequencer_assert.svh"

module les_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wen,
  input logic [les_pkg::PERIOD_WIDTH-1:0] cfg_wdata,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [les_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [les_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import les_pkg::*;

  // no result pending right after reset
  `LES_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // back-pressure only once the output entry is occupied
  `LES_ASSERT(a_ready_low_full, !in_tready |-> out_tvalid, "input stalled with empty output")

  // unused result bits stay clear
  `LES_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_USED_W] == '0,
              "result padding bits set")

  // a stalled result word holds
  `LES_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
              "stalled result changed")

endmodule

bind led_effect_sequencer les_checker u_les_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_wen    (cfg_wen),
  .cfg_wdata  (cfg_wdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/led_word_checker.sv
module led_word_checker
  import les_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wen,
  input  logic [PERIOD_WIDTH-1:0] cfg_wdata,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,    // opcode[3:0], argument[11:4]
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [OUT_DATA_W-1:0]   out_tdata,   // led_pattern[7:0], busy_res[8], rejected[9]
  output int                      fail_count,
  output int                      words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LED_W-1:0] leds;
    logic             busy;
    logic             rej;
  } led_word_t;

  led_word_t led_words_due[$];

  logic [PERIOD_WIDTH-1:0] period;
  logic [LED_W-1:0]        leds;
  logic [OPCODE_W-1:0]     effect;
  logic [ARG_W-1:0]        cycles_left;
  logic [IDX_W-1:0]        frame;
  logic [PERIOD_WIDTH-1:0] wait_left;
  logic                    tail;

  function automatic logic [PERIOD_WIDTH-1:0] frac_wait(input logic [3:0] div);
    logic [PERIOD_WIDTH-1:0] w;
    w = period / div;
    return (w == '0) ? PERIOD_WIDTH'(1) : w;
  endfunction

  function automatic void led_on(input int b);
    if (b >= 0 && b < LED_W) leds[b] = 1'b1;
  endfunction

  function automatic void led_off(input int b);
    if (b >= 0 && b < LED_W) leds[b] = 1'b0;
  endfunction

  function automatic logic [IDX_W-1:0] frame_count(input logic [OPCODE_W-1:0] eff);
    case (eff)
      FX_SLIDE, FX_GROW:   return IDX_W'(9);
      FX_BLINK, FX_BIBLINK: return IDX_W'(2);
      FX_BISLIDE:          return IDX_W'(16);
      FX_CENTER, FX_SIDE:  return IDX_W'(5);
      FX_BISIDE:           return IDX_W'(8);
      default:             return IDX_W'(1);
    endcase
  endfunction

  function automatic void stop_effect();
    effect = FX_IDLE;
    cycles_left = '0;
    frame = '0;
    wait_left = '0;
    tail = 1'b0;
  endfunction

  // light the pair at position h, darken the pair one step behind
  function automatic void pair_step(input int h, input bit lit, input bit dark);
    if (lit) begin
      led_on(h - 1);
      led_on(8 - h);
    end
    if (dark) begin
      led_off(h - 2);
      led_off(9 - h);
    end
  endfunction

  // apply the current frame, return its wait divisor (0: no wait)
  function automatic logic [3:0] show_frame();
    int idx;
    int h;
    idx = int'(frame);
    case (effect)
      FX_SLIDE: begin
        h = idx + 1;
        if (h <= 8) led_on(h - 1);
        if (h != 1) led_off(h - 2);
        return 4'd8;
      end
      FX_BLINK: begin
        leds = (idx == 0) ? 8'hFF : 8'h00;
        return 4'd2;
      end
      FX_BISLIDE: begin
        if (idx < 8) begin
          led_on(idx);
          if (idx != 0) led_off(idx - 1);
        end else begin
          h = 16 - idx;
          led_on(h - 1);
          if (h != 8) led_off(h);
        end
        return 4'd8;
      end
      FX_BIBLINK: begin
        leds = (idx == 0) ? 8'h55 : 8'hAA;
        return 4'd2;
      end
      FX_GROW: begin
        if (idx < 8) led_on(idx);
        else leds = '0;
        return 4'd9;
      end
      FX_CENTER: begin
        h = idx + 1;
        pair_step(h, h <= 4, h != 1);
        return 4'd8;
      end
      FX_SIDE: begin
        h = idx + 5;
        pair_step(h, h <= 8, h != 5);
        return 4'd8;
      end
      FX_BISIDE: begin
        if (idx < 4) begin
          h = idx + 5;
          pair_step(h, 1'b1, h != 5);
          return (h != 8) ? 4'd8 : 4'd0;
        end
        h = idx - 3;
        pair_step(h, 1'b1, h != 1);
        return (h != 4) ? 4'd8 : 4'd0;
      end
      default: return 4'd8;
    endcase
  endfunction

  function automatic void wind_down();
    case (effect)
      FX_BISLIDE: begin
        led_off(0);
        stop_effect();
      end
      FX_BIBLINK: begin
        leds = '0;
        stop_effect();
      end
      FX_BISIDE: begin
        tail = 1'b1;
        wait_left = frac_wait(4'd8);
      end
      default: stop_effect();
    endcase
  endfunction

  function automatic bit next_frame();
    frame = frame + 1'b1;
    if (frame >= frame_count(effect)) begin
      frame = '0;
      cycles_left = cycles_left - 1'b1;
      if (cycles_left == '0) begin
        wind_down();
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // frames without a wait fold into the following one
  function automatic void run_frames();
    logic [3:0] div;
    bit going;
    going = 1'b1;
    while (going) begin
      div = show_frame();
      if (div != 4'd0) begin
        wait_left = frac_wait(div);
        going = 1'b0;
      end else begin
        going = next_frame();
      end
    end
  endfunction

  function automatic void tick_effect();
    if (effect == FX_IDLE) return;
    if (wait_left > 1) begin
      wait_left = wait_left - 1'b1;
      return;
    end
    wait_left = '0;
    if (tail) begin
      leds = '0;
      stop_effect();
      return;
    end
    if (next_frame()) run_frames();
  endfunction

  function automatic led_word_t predict_word(input logic [OPCODE_W-1:0] op,
                                             input logic [ARG_W-1:0] arg);
    led_word_t w;
    logic rej;
    rej = 1'b0;
    if (op == OP_TICK) begin
      tick_effect();
    end else if (effect != FX_IDLE || op > FX_BISIDE) begin
      rej = 1'b1;
    end else if (op == OP_ON || op == OP_OFF) begin
      if (arg > 8) rej = 1'b1;
      else if (arg == 0) leds = (op == OP_ON) ? 8'hFF : 8'h00;
      else if (op == OP_ON) led_on(int'(arg) - 1);
      else led_off(int'(arg) - 1);
    end else if (op == OP_BAR) begin
      if (arg == 0 || arg > 8) rej = 1'b1;
      else leds = LED_W'((9'd1 << arg) - 9'd1);
    end else if (op == OP_MASK) begin
      leds = arg;
    end else begin
      effect = op;
      cycles_left = arg;
      frame = '0;
      tail = 1'b0;
      wait_left = '0;
      if (arg == 0) wind_down();
      else run_frames();
    end
    w.leds = leds;
    w.busy = (effect != FX_IDLE);
    w.rej = rej;
    return w;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // retire results before queuing the word accepted at this edge
  always @(posedge clk) begin
    led_word_t want;
    if (!rst_n) begin
      period = PERIOD_WIDTH'(PERIOD_RESET);
      leds = '0;
      stop_effect();
      led_words_due.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (led_words_due.size() == 0) begin
          $display("%0t unexpected result word: expected none, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = led_words_due.pop_front();
          check_field("led_pattern", want.leds, out_tdata[LED_W-1:0]);
          check_field("busy_res", want.busy, out_tdata[LED_W]);
          check_field("rejected", want.rej, out_tdata[LED_W+1]);
        end
      end
      if (cfg_wen) period = cfg_wdata;
      if (in_tvalid && in_tready)
        led_words_due.push_back(predict_word(in_tdata[OPCODE_W-1:0],
                                             in_tdata[OPCODE_W +: ARG_W]));
    end
    words_due = led_words_due.size();
  end

endmodule

>>> test/tb.sv
module tb;
  import les_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL    = 1400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int IDLE_PCT     = 29;
  localparam int DRAIN_CYCLES = 20;
  localparam int CALM_IN_LO   = 500;
  localparam int CALM_IN_HI   = 760;
  localparam int CALM_OUT_LO  = 1500;
  localparam int CALM_OUT_HI  = 2600;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MIN = PERIOD_WIDTH'(9);

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wen = 1'b0;
  logic [PERIOD_WIDTH-1:0] cfg_wdata = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;

  int   fail_count;
  int   words_due;
  int   cycle_count = 0;
  int   sent_total = 0;
  logic seen_busy = 1'b0;

  led_effect_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  led_word_checker led_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .words_due (words_due)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) begin
    out_tready <= (cycle_count >= CALM_OUT_LO && cycle_count < CALM_OUT_HI) ||
                  ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // steer stimulus by the busy flag of the latest result word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) seen_busy <= out_tdata[LED_W];
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL led_effect_sequencer");
    $finish;
  end

  // called and returns at a falling edge
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [ARG_W-1:0] arg);
    while (!(sent_total >= CALM_IN_LO && sent_total < CALM_IN_HI) &&
           $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({arg, op});
    do @(posedge clk); while (!in_tready);
    sent_total++;
    @(negedge clk);
  endtask

  task automatic set_period(input logic [PERIOD_WIDTH-1:0] value);
    in_tvalid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic pick_command(output logic [OPCODE_W-1:0] op, output logic [ARG_W-1:0] arg);
    int r;
    int p;
    r = $urandom_range(0, 99);
    arg = ARG_W'($urandom);
    if (seen_busy && r < 88) begin
      op = OP_TICK;
    end else if (seen_busy) begin
      // noise while an effect runs
      op = OPCODE_W'($urandom_range(OP_ON, 15));
    end else if (r < 20) begin
      op = OP_TICK;
    end else if (r < 50) begin
      op = OPCODE_W'($urandom_range(FX_SLIDE, FX_BISIDE));
      p = $urandom_range(0, 99);
      if (p < 70) arg = ARG_W'($urandom_range(0, 2));
      else if (p < 95) arg = ARG_W'($urandom_range(3, 8));
      else if (p < 98) arg = ARG_W'($urandom_range(9, 40));
      else op = $urandom_range(0, 1) ? FX_BLINK : FX_BIBLINK;
    end else if (r < 64) begin
      op = $urandom_range(0, 1) ? OP_ON : OP_OFF;
      if ($urandom_range(0, 4) != 0) arg = ARG_W'($urandom_range(0, 9));
    end else if (r < 74) begin
      op = OP_BAR;
      if ($urandom_range(0, 4) != 0) arg = ARG_W'($urandom_range(0, 9));
    end else if (r < 94) begin
      op = OP_MASK;
    end else begin
      op = OPCODE_W'($urandom_range(13, 15));
    end
  endtask

  initial begin
    logic [OPCODE_W-1:0]     op;
    logic [ARG_W-1:0]        arg;
    logic [PERIOD_WIDTH-1:0] next_period;
    int                      n;
    int                      p;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // manual commands under the reset period, bad arguments, unused opcodes
    send_word(OP_ON, 8'd0);
    send_word(OP_OFF, 8'd3);
    send_word(OP_ON, 8'd9);
    send_word(OP_OFF, 8'd0);
    send_word(OP_ON, 8'd8);
    send_word(OP_OFF, 8'd255);
    send_word(OP_BAR, 8'd0);
    send_word(OP_BAR, 8'd8);
    send_word(OP_BAR, 8'd1);
    send_word(OP_BAR, 8'd9);
    send_word(OP_MASK, 8'hA5);
    send_word(OP_TICK, 8'hFF);
    send_word(4'd13, 8'd0);
    send_word(4'd15, 8'd255);
    // zero repeat counts only run the ending action
    send_word(FX_SLIDE, 8'd0);
    send_word(OP_MASK, 8'hFF);
    send_word(FX_BISLIDE, 8'd0);
    send_word(FX_BIBLINK, 8'd0);

    set_period(PERIOD_MAX);
    send_word(OP_MASK, 8'h5A);
    send_word(FX_GROW, 8'd0);
    send_word(OP_TICK, 8'd0);

    set_period(PERIOD_MIN);
    send_word(FX_BISIDE, 8'd0);
    send_word(OP_TICK, 8'd0);
    send_word(OP_TICK, 8'd0);
    send_word(FX_SLIDE, 8'd1);
    send_word(OP_ON, 8'd1);
    send_word(OP_MASK, 8'd0);

    // the first phase rewrites the period while the slide still runs
    while (sent_total < ITEM_GOAL) begin
      p = $urandom_range(0, 99);
      if (p < 60) next_period = PERIOD_WIDTH'($urandom_range(9, 32));
      else if (p < 80) next_period = PERIOD_WIDTH'($urandom_range(33, 120));
      else if (p < 90) next_period = PERIOD_MIN;
      else next_period = PERIOD_WIDTH'($urandom_range(121, 200));
      set_period(next_period);
      n = $urandom_range(60, 140);
      repeat (n) begin
        if (sent_total < ITEM_GOAL) begin
          pick_command(op, arg);
          send_word(op, arg);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS led_effect_sequencer");
    end else begin
      $display("FAIL led_effect_sequencer");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/les_pkg.sv
rtl/led_effect_sequencer.sv
rtl/les_checker.sv
test/led_word_checker.sv
test/tb.sv
